// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// shared widths, codes and types of the preemptive priority scheduler
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int PPS_MAX_PENDING = 32;

   localparam int TIME_W = 48;
   localparam int WORD_W = 32;
   localparam int TAG_W  = 16;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   // operation codes of an input word
   localparam logic OPER_ARRIVE = 1'b0;
   localparam logic OPER_DRAIN  = 1'b1;

   // status codes of a result word
   localparam logic STATUS_DONE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [WORD_W-1:0] prio;
      logic [WORD_W-1:0] rem;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef enum logic [1:0] {
      OP_NOP,
      OP_POP,
      OP_PUSH,
      OP_SETREM
   } chain_op_type;

   typedef struct packed {
      chain_op_type      op;
      entry_type         job;
      logic [WORD_W-1:0] rem;
   } chain_cmd_type;

   typedef struct packed {
      entry_type head;
      logic      full;
   } chain_status_type;

endpackage

// ===== src/pps_ifs.sv =====
// ----------------------------------------------------------------------------
// pps_ifs
// valid/ready channels for job words and result words
// ----------------------------------------------------------------------------
interface pps_req_if;
   import pps_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [WORD_W-1:0] arrival_time;
   logic [WORD_W-1:0] job_size;
   logic [WORD_W-1:0] job_priority;
   logic [TAG_W-1:0]  job_tag;

   modport source (output valid, operation, arrival_time, job_size, job_priority, job_tag,
                   input ready);
   modport sink   (input valid, operation, arrival_time, job_size, job_priority, job_tag,
                   output ready);
endinterface

interface pps_rsp_if;
   import pps_pkg::*;

   logic              valid;
   logic              ready;
   logic [TAG_W-1:0]  done_tag;
   logic [TIME_W-1:0] finish_time;
   logic              status;
   logic              last;

   modport source (output valid, done_tag, finish_time, status, last, input ready);
   modport sink   (input valid, done_tag, finish_time, status, last, output ready);
endinterface

// ===== src/preemptive_priority_scheduler_core.sv =====
// steps: a taken word first settles the head, then each completed job is selected and the
//   head cell reloaded, and an arrival is then stored or rejected; the held result is
//   flushed as the last result word
// a new input word is taken only in the idle state, once the last result of the previous
//   word is registered; output stalls hold completions and the final flush
// reset: synchronous, active high; clears time, all chain slots and the output register
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// single-server preemptive priority scheduler built on a sorted chain of job cells
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_core #(
   parameter int MAX_PENDING = pps_pkg::PPS_MAX_PENDING
) (
   input  logic  clock,
   input  logic  reset,
   pps_req_if.sink   req_ch,
   pps_rsp_if.source rsp_ch
);
   import pps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DECIDE,
      ST_INSERT
   } state_type;

   // the finish step shares the insert code point via a flag
   state_type state_ff, state_in;
   logic      finish_ff, finish_in;

   // word being worked on
   logic              drain_ff,  drain_in;
   logic [TIME_W-1:0] target_ff, target_in;
   entry_type         job_ff,    job_in;

   // scheduler time and head finish sum (one bit wider for saturation)
   logic [TIME_W-1:0] cur_time_ff, cur_time_in;
   logic [TIME_W:0]   sum_ff,      sum_in;

   // one result held back until we know whether it is the last one
   logic              pend_valid_ff,  pend_valid_in;
   logic [TAG_W-1:0]  pend_tag_ff,    pend_tag_in;
   logic [TIME_W-1:0] pend_time_ff,   pend_time_in;
   logic              pend_status_ff, pend_status_in;

   // output register
   logic              rsp_valid_ff,  rsp_valid_in;
   logic [TAG_W-1:0]  rsp_tag_ff,    rsp_tag_in;
   logic [TIME_W-1:0] rsp_time_ff,   rsp_time_in;
   logic              rsp_status_ff, rsp_status_in;
   logic              rsp_last_ff,   rsp_last_in;

   chain_cmd_type    cmd;
   chain_status_type chain_st;

   logic              out_free;
   logic              can_emit;
   logic              req_take;
   logic [TIME_W-1:0] arrival_ext;
   logic [TIME_W-1:0] fin;
   logic              fin_fits;
   logic [TIME_W:0]   over;

   pps_chain #(
      .MAX_PENDING (MAX_PENDING)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (chain_st)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.done_tag    = rsp_tag_ff;
   assign rsp_ch.finish_time = rsp_time_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // output register can take a word this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   // room to park a new result in the holding register
   assign can_emit = !pend_valid_ff || out_free;

   // late arrivals are served from the current time
   assign arrival_ext = {{(TIME_W-WORD_W){1'b0}}, req_ch.arrival_time};

   // head finish time, saturated at the top of the time range
   assign fin      = sum_ff[TIME_W] ? TIME_MAX : sum_ff[TIME_W-1:0];
   assign fin_fits = (fin <= target_ff);
   // work left on a preempted head job, below 2^32 whenever it is used
   assign over     = sum_ff - {1'b0, target_ff};

   always_comb begin
      state_in       = state_ff;
      finish_in      = finish_ff;
      drain_in       = drain_ff;
      target_in      = target_ff;
      job_in         = job_ff;
      cur_time_in    = cur_time_ff;
      sum_in         = sum_ff;
      pend_valid_in  = pend_valid_ff;
      pend_tag_in    = pend_tag_ff;
      pend_time_in   = pend_time_ff;
      pend_status_in = pend_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_tag_in     = rsp_tag_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;

      cmd.op  = OP_NOP;
      cmd.job = job_ff;
      cmd.rem = over[WORD_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               drain_in     = (req_ch.operation == OPER_DRAIN);
               target_in    = (arrival_ext > cur_time_ff) ? arrival_ext : cur_time_ff;
               job_in.valid = 1'b1;
               job_in.prio  = req_ch.job_priority;
               job_in.rem   = req_ch.job_size;
               job_in.tag   = req_ch.job_tag;
               sum_in       = {1'b0, cur_time_ff} +
                              {{(TIME_W+1-WORD_W){1'b0}}, chain_st.head.rem};
               finish_in    = 1'b0;
               state_in     = ST_DECIDE;
            end
         end

         // new head after a pop, form its finish sum
         ST_LOAD: begin
            sum_in   = {1'b0, cur_time_ff} +
                       {{(TIME_W+1-WORD_W){1'b0}}, chain_st.head.rem};
            state_in = ST_DECIDE;
         end

         ST_DECIDE: begin
            if (!chain_st.head.valid) begin
               // store empty: an arrival moves time up to its target
               if (!drain_ff) begin
                  cur_time_in = target_ff;
               end
               finish_in = drain_ff;
               state_in  = ST_INSERT;
            end else if (drain_ff || fin_fits) begin
               // head job completes on the way
               if (can_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_tag_in    = pend_tag_ff;
                     rsp_time_in   = pend_time_ff;
                     rsp_status_in = pend_status_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_tag_in    = chain_st.head.tag;
                  pend_time_in   = fin;
                  pend_status_in = STATUS_DONE;
                  cur_time_in    = fin;
                  cmd.op         = OP_POP;
                  state_in       = ST_LOAD;
               end
            end else begin
               // head job is preempted at the target time
               cmd.op      = OP_SETREM;
               cur_time_in = target_ff;
               state_in    = ST_INSERT;
            end
         end

         ST_INSERT: begin
            if (finish_ff) begin
               // flush the held result as the last word of this item
               if (!pend_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_tag_in    = pend_tag_ff;
                  rsp_time_in   = pend_time_ff;
                  rsp_status_in = pend_status_ff;
                  rsp_last_in   = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end else if (chain_st.full) begin
               // no free slot: the arrival is rejected at the current time
               if (can_emit) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_tag_in    = pend_tag_ff;
                     rsp_time_in   = pend_time_ff;
                     rsp_status_in = pend_status_ff;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_tag_in    = job_ff.tag;
                  pend_time_in   = cur_time_ff;
                  pend_status_in = STATUS_REJECT;
                  finish_in      = 1'b1;
               end
            end else begin
               cmd.op    = OP_PUSH;
               finish_in = 1'b1;
               if (!pend_valid_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         finish_ff     <= 1'b0;
         cur_time_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         finish_ff     <= finish_in;
         cur_time_ff   <= cur_time_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      drain_ff       <= drain_in;
      target_ff      <= target_in;
      job_ff         <= job_in;
      sum_ff         <= sum_in;
      pend_tag_ff    <= pend_tag_in;
      pend_time_ff   <= pend_time_in;
      pend_status_ff <= pend_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_time_ff    <= rsp_time_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // time never runs backward while a word is in progress
   a_time_mono: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |=> cur_time_ff >= $past(cur_time_ff))
      else $error("scheduler time moved backward");

   // nothing is held back once the block is ready for a new word
   a_idle_flushed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held result left behind at end of word");

   // a completion is never later than the time it leaves behind
   a_fin_bound: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff && pend_status_ff == STATUS_DONE |-> pend_time_ff <= cur_time_ff)
      else $error("completion time beyond scheduler time");

endmodule

// ===== src/pps_cell.sv =====
// ----------------------------------------------------------------------------
// pps_cell
// one slot of the sorted job chain, shifts toward either neighbor
// ----------------------------------------------------------------------------
module pps_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    is_head,
   input  pps_pkg::chain_cmd_type  cmd,
   input  pps_pkg::entry_type      left_entry,
   input  logic                    left_yields,
   input  pps_pkg::entry_type      right_entry,
   output pps_pkg::entry_type      entry,
   output logic                    yields
);
   import pps_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // new job goes ahead of equal priorities, it is the latest arrival
   assign yields = !entry_ff.valid || (cmd.job.prio >= entry_ff.prio);
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (cmd.op)
         OP_POP: begin
            entry_in = right_entry;
         end
         OP_PUSH: begin
            if (yields) begin
               if (left_yields) begin
                  entry_in = left_entry;
               end else begin
                  entry_in       = cmd.job;
                  entry_in.valid = 1'b1;
               end
            end
         end
         OP_SETREM: begin
            if (is_head) begin
               entry_in.rem = cmd.rem;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== src/pps_chain.sv =====
// ----------------------------------------------------------------------------
// pps_chain
// row of cells kept sorted by priority, head cell holds the job in service
// ----------------------------------------------------------------------------
module pps_chain #(
   parameter int MAX_PENDING = pps_pkg::PPS_MAX_PENDING
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pps_pkg::chain_cmd_type    cmd,
   output pps_pkg::chain_status_type status
);
   import pps_pkg::*;

   entry_type entry_w  [MAX_PENDING];
   logic      yields_w [MAX_PENDING];

   genvar i;
   generate
      for (i = 0; i < MAX_PENDING; i++) begin : g_cell
         entry_type left_entry;
         logic      left_yields;
         entry_type right_entry;

         if (i == 0) begin : g_first
            assign left_entry  = '0;
            assign left_yields = 1'b0;
         end else begin : g_inner_left
            assign left_entry  = entry_w[i-1];
            assign left_yields = yields_w[i-1];
         end

         if (i == MAX_PENDING - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_inner_right
            assign right_entry = entry_w[i+1];
         end

         pps_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .is_head     (i == 0),
            .cmd         (cmd),
            .left_entry  (left_entry),
            .left_yields (left_yields),
            .right_entry (right_entry),
            .entry       (entry_w[i]),
            .yields      (yields_w[i])
         );
      end
   endgenerate

   // packed at the front, so the last cell tells whether the row is full
   assign status.head = entry_w[0];
   assign status.full = entry_w[MAX_PENDING-1].valid;

   generate
      for (i = 0; i < MAX_PENDING - 1; i++) begin : g_order_chk
         a_sorted: assert property (@(posedge clock) disable iff (reset)
            entry_w[i+1].valid |-> entry_w[i].valid && entry_w[i].prio >= entry_w[i+1].prio)
            else $error("job chain lost its priority order");
      end
   endgenerate

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_PUSH |-> !status.full)
      else $error("push into a full job chain");

endmodule
